// ===== src/bfpa_pkg.sv =====
// bfpa_pkg: shared types and constants for the best-fit partition allocator
// holds operation codes, field widths and the controller/datapath command and status structs
// no dependencies
package bfpa_pkg;

   // field widths of one transaction
   localparam int IDX_W  = 6;
   localparam int SIZE_W = 16;
   localparam int SUM_W  = 32;

   // number of partitions that the index field can reach
   localparam int IDX_DEPTH = 2 ** IDX_W;

   // operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_ALLOC = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic capture;     // take in the request fields, clear the search result
      logic load_write;  // write the size table and set the free mark
      logic read;        // read the entry under the scan pointer and advance it
      logic commit;      // take the chosen partition and form the wastage
      logic finish;      // update the running sum and the result registers
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic op_alloc;    // incoming request is an allocate
      logic scan_last;   // scan pointer sits on the last partition
   } dp_status_type;

endpackage

// ===== src/bfpa_dp.sv =====
// bfpa_dp: datapath of the best-fit partition allocator
// size table memory, free marks, scan pointer, best-fit compare and wastage sum
// depends on bfpa_pkg
module bfpa_dp #(
   parameter int NUM_PARTITIONS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bfpa_pkg::dp_cmd_type          cmd,
   output bfpa_pkg::dp_status_type       status,
   input  logic                          req_op,
   input  logic [bfpa_pkg::IDX_W-1:0]    req_block_index,
   input  logic [bfpa_pkg::SIZE_W-1:0]   req_size_value,
   output logic                          rsp_granted,
   output logic [bfpa_pkg::IDX_W-1:0]    rsp_chosen_index,
   output logic [bfpa_pkg::SIZE_W-1:0]   rsp_wastage,
   output logic [bfpa_pkg::SUM_W-1:0]    rsp_total_wastage
);
   import bfpa_pkg::*;

   // only partitions the index field reaches can ever be loaded and become free
   localparam int LOADABLE = (NUM_PARTITIONS < IDX_DEPTH) ? NUM_PARTITIONS : IDX_DEPTH;
   localparam int ADDR_W   = $clog2(LOADABLE);

   // captured request
   logic [IDX_W-1:0]      req_index_ff;
   logic [SIZE_W-1:0]     req_size_ff;

   // table storage
   logic [SIZE_W-1:0]     size_mem [LOADABLE];
   logic [LOADABLE-1:0]   free_ff;

   // scan pipeline
   logic [ADDR_W-1:0]     scan_ff;
   logic                  rd_valid_ff;
   logic                  rd_free_ff;
   logic [SIZE_W-1:0]     rd_size_ff;
   logic [ADDR_W-1:0]     rd_idx_ff;

   // search result
   logic                  found_ff;
   logic [ADDR_W-1:0]     best_idx_ff;
   logic [SIZE_W-1:0]     best_size_ff;
   logic [SIZE_W-1:0]     waste_ff;

   // running sum and result registers
   logic [SUM_W-1:0]      sum_ff;
   logic [SUM_W-1:0]      sum_in;
   logic [SUM_W:0]        sum_wide;
   logic                  rsp_granted_ff;
   logic [IDX_W-1:0]      rsp_index_ff;
   logic [SIZE_W-1:0]     rsp_waste_ff;

   logic                  load_ok;
   logic [ADDR_W-1:0]     load_addr;
   logic                  better;

   // load goes only to partitions that exist
   assign load_ok   = ({{(32-IDX_W){1'b0}}, req_index_ff} < 32'(LOADABLE));
   assign load_addr = req_index_ff[ADDR_W-1:0];

   assign status.op_alloc  = (req_op == OP_ALLOC);
   assign status.scan_last = (scan_ff == ADDR_W'(LOADABLE - 1));

   // candidate fits and beats the best so far; strict less keeps the lowest index on ties
   assign better = rd_valid_ff && rd_free_ff && (rd_size_ff >= req_size_ff) &&
                   (!found_ff || (rd_size_ff < best_size_ff));

   // saturating add of the wastage into the running sum
   assign sum_wide = {1'b0, sum_ff} + {{(SUM_W-SIZE_W+1){1'b0}}, waste_ff};
   assign sum_in   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_index_ff <= req_block_index;
         req_size_ff  <= req_size_value;
      end
   end

   // size table write port and registered read port
   always_ff @(posedge clock) begin
      if (cmd.load_write && load_ok) begin
         size_mem[load_addr] <= req_size_ff;
      end
      if (cmd.read) begin
         rd_size_ff <= size_mem[scan_ff];
      end
   end

   // free marks: set by a load, cleared by a grant
   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= '0;
      end else if (cmd.load_write && load_ok) begin
         free_ff[load_addr] <= 1'b1;
      end else if (cmd.commit && found_ff) begin
         free_ff[best_idx_ff] <= 1'b0;
      end
   end

   // scan pointer and read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.read;
         if (cmd.capture) begin
            scan_ff <= '0;
         end else if (cmd.read) begin
            scan_ff <= scan_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_free_ff <= free_ff[scan_ff];
         rd_idx_ff  <= scan_ff;
      end
   end

   // best-fit tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.capture) begin
         found_ff <= 1'b0;
      end else if (better) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         best_idx_ff  <= '0;
         best_size_ff <= '0;
      end else if (better) begin
         best_idx_ff  <= rd_idx_ff;
         best_size_ff <= rd_size_ff;
      end
   end

   // wastage of the grant, zero for loads and misses
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         waste_ff <= '0;
      end else if (cmd.commit && found_ff) begin
         waste_ff <= best_size_ff - req_size_ff;
      end
   end

   // running sum and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (cmd.finish) begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_granted_ff <= found_ff;
         rsp_index_ff   <= found_ff ? IDX_W'(best_idx_ff) : '0;
         rsp_waste_ff   <= waste_ff;
      end
   end

   assign rsp_granted       = rsp_granted_ff;
   assign rsp_chosen_index  = rsp_index_ff;
   assign rsp_wastage       = rsp_waste_ff;
   assign rsp_total_wastage = sum_ff;

   // a granted partition is no longer free afterwards
   a_grant_clears_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && found_ff |=> !free_ff[$past(best_idx_ff)])
      else $error("granted partition still marked free");

   // the best candidate always fits the request
   a_best_fits: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> best_size_ff >= req_size_ff)
      else $error("best candidate smaller than request");

   // the running sum never decreases
   a_sum_monotonic: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> sum_ff >= $past(sum_ff))
      else $error("wastage sum decreased");

endmodule

// ===== src/bfpa_ctrl.sv =====
// bfpa_ctrl: controller state machine of the best-fit partition allocator
// sequences load, scan, commit and finish steps and drives busy and the result strobe
// depends on bfpa_pkg
module bfpa_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   output logic                     rsp_strobe,
   output bfpa_pkg::dp_cmd_type     cmd,
   input  bfpa_pkg::dp_status_type  status
);
   import bfpa_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOAD   = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_COMMIT = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       strobe_ff;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = status.op_alloc ? ST_SCAN : ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load_write = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_SCAN: begin
            cmd.read = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last entry is being compared
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and strobe registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= (state_ff == ST_FINISH);
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

   // an accepted transaction always leaves idle toward load or scan
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> state_ff == ST_LOAD || state_ff == ST_SCAN)
      else $error("accepted transaction did not start");

   // the strobe follows the finish step only
   a_strobe_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == ST_FINISH)
      else $error("strobe without finish step");

   // one result per transaction: the strobe is never raised back to back
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("strobe held for two cycles");

endmodule

// ===== src/best_fit_partition_allocator.sv =====
// Best-fit fixed partition allocator. A load (op 0) writes the size of one partition and
// marks it free; an allocate (op 1) picks the smallest free partition at least as large as
// the request, lowest index on ties, marks it taken and reports the wastage and a running
// total that saturates at 2^32-1. A transaction is taken when start is high and busy is low;
// its result appears for exactly one cycle with rsp_strobe high and must be taken then.
// A load passes through the load and finish steps; an allocate scans all P loadable partitions
// (P = min(NUM_PARTITIONS, 64)), reading the size table memory one entry per cycle, then
// drains, commits and finishes. The next transaction may be started in the strobe cycle.
// Partitions never loaded are not free; no clearing pass is needed after reset.
// Depends on bfpa_pkg, bfpa_ctrl and bfpa_dp.
module best_fit_partition_allocator #(
   parameter int NUM_PARTITIONS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_op,
   input  logic [bfpa_pkg::IDX_W-1:0]    req_block_index,
   input  logic [bfpa_pkg::SIZE_W-1:0]   req_size_value,
   output logic                          rsp_strobe,
   output logic                          rsp_granted,
   output logic [bfpa_pkg::IDX_W-1:0]    rsp_chosen_index,
   output logic [bfpa_pkg::SIZE_W-1:0]   rsp_wastage,
   output logic [bfpa_pkg::SUM_W-1:0]    rsp_total_wastage
);
   import bfpa_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // controller
   bfpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   // datapath
   bfpa_dp #(
      .NUM_PARTITIONS (NUM_PARTITIONS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_op            (req_op),
      .req_block_index   (req_block_index),
      .req_size_value    (req_size_value),
      .rsp_granted       (rsp_granted),
      .rsp_chosen_index  (rsp_chosen_index),
      .rsp_wastage       (rsp_wastage),
      .rsp_total_wastage (rsp_total_wastage)
   );

endmodule

// ===== test/bfpa_grant_monitor.sv =====
// bfpa_grant_monitor: watches the request and result channels of the partition allocator,
// predicts every result from its own copy of the partition table and compares field by field
// depends on bfpa_pkg
module bfpa_grant_monitor #(
   parameter int NUM_PARTITIONS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic                        req_op,
   input  logic [bfpa_pkg::IDX_W-1:0]  req_block_index,
   input  logic [bfpa_pkg::SIZE_W-1:0] req_size_value,
   input  logic                        rsp_strobe,
   input  logic                        rsp_granted,
   input  logic [bfpa_pkg::IDX_W-1:0]  rsp_chosen_index,
   input  logic [bfpa_pkg::SIZE_W-1:0] rsp_wastage,
   input  logic [bfpa_pkg::SUM_W-1:0]  rsp_total_wastage,
   output int                          outstanding,
   output int                          mismatches,
   output int                          grant_count,
   output int                          miss_count,
   output int                          load_count
);
   import bfpa_pkg::*;

   // entries past the reach of the index field can never be loaded
   localparam int LOADABLE = (NUM_PARTITIONS < IDX_DEPTH) ? NUM_PARTITIONS : IDX_DEPTH;

   typedef struct packed {
      logic              granted;
      logic [IDX_W-1:0]  index;
      logic [SIZE_W-1:0] waste;
      logic [SUM_W-1:0]  total;
   } grant_type;

   // shadow of the partition table and the running wastage sum
   logic [SIZE_W-1:0] part_size [LOADABLE];
   logic              part_free [LOADABLE];
   logic [SUM_W-1:0]  waste_total;
   grant_type         grant_q [$];

   // apply one transaction to the shadow table and return the result it should give
   function automatic grant_type predict_grant(logic op, logic [IDX_W-1:0] idx,
                                               logic [SIZE_W-1:0] size);
      grant_type         r;
      logic              found;
      int                best;
      logic [SIZE_W-1:0] best_size;
      logic [SUM_W:0]    sum;
      r = '0;
      found = 1'b0;
      best = 0;
      best_size = '0;
      if (op == OP_LOAD) begin
         if (idx < LOADABLE) begin
            part_size[idx] = size;
            part_free[idx] = 1'b1;
         end
      end else begin
         // smallest free partition that fits, lowest index on ties
         for (int j = 0; j < LOADABLE; j++) begin
            if (part_free[j] && part_size[j] >= size && (!found || part_size[j] < best_size)) begin
               found = 1'b1;
               best = j;
               best_size = part_size[j];
            end
         end
         if (found) begin
            part_free[best] = 1'b0;
            r.granted = 1'b1;
            r.index = best[IDX_W-1:0];
            r.waste = best_size - size;
            // saturating sum
            sum = {1'b0, waste_total} + {{(SUM_W-SIZE_W+1){1'b0}}, r.waste};
            waste_total = sum[SUM_W] ? '1 : sum[SUM_W-1:0];
         end
      end
      r.total = waste_total;
      return r;
   endfunction

   task automatic report_field(string name, logic [SUM_W-1:0] want, logic [SUM_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // sample both channels at each rising edge
   always @(posedge clock) begin : watch
      grant_type want;
      grant_type got;
      if (reset) begin
         for (int i = 0; i < LOADABLE; i++) part_free[i] = 1'b0;
         waste_total = '0;
         grant_q.delete();
         outstanding <= 0;
         mismatches = 0;
         grant_count = 0;
         miss_count = 0;
         load_count = 0;
      end else begin
         // accepted request transaction
         if (start && !busy) begin
            want = predict_grant(req_op, req_block_index, req_size_value);
            grant_q.push_back(want);
            if (req_op == OP_LOAD) load_count++;
            else if (!want.granted) miss_count++;
         end
         // result transaction
         if (rsp_strobe) begin
            got.granted = rsp_granted;
            got.index = rsp_chosen_index;
            got.waste = rsp_wastage;
            got.total = rsp_total_wastage;
            if (grant_q.size() == 0) begin
               mismatches++;
               $display("%0t: result mismatch, expected no result, actual granted %0d index %0d",
                        $time, got.granted, got.index);
            end else begin
               want = grant_q.pop_front();
               report_field("granted", SUM_W'(want.granted), SUM_W'(got.granted));
               report_field("chosen_index", SUM_W'(want.index), SUM_W'(got.index));
               report_field("wastage", SUM_W'(want.waste), SUM_W'(got.waste));
               report_field("total_wastage", want.total, got.total);
               if (want.granted) grant_count++;
            end
         end
         outstanding <= grant_q.size();
      end
   end

endmodule

// ===== test/tb.sv =====
// tb: top of the best-fit partition allocator regression
// drives load and allocate transactions and gives the verdict from the grant monitor
// depends on bfpa_pkg, best_fit_partition_allocator and bfpa_grant_monitor
module tb;
   import bfpa_pkg::*;

   localparam int NUM_PARTITIONS = 64;
   localparam int RANDOM_ITEMS   = 1670;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 80;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_op;
   logic [IDX_W-1:0]  req_block_index;
   logic [SIZE_W-1:0] req_size_value;
   logic              rsp_strobe;
   logic              rsp_granted;
   logic [IDX_W-1:0]  rsp_chosen_index;
   logic [SIZE_W-1:0] rsp_wastage;
   logic [SUM_W-1:0]  rsp_total_wastage;

   int outstanding;
   int mismatches;
   int grant_count;
   int miss_count;
   int load_count;
   int idle_cycles;
   int alloc_count;
   bit no_gaps;
   logic [SIZE_W-1:0] size_pool [6];

   best_fit_partition_allocator #(.NUM_PARTITIONS(NUM_PARTITIONS)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_block_index(req_block_index), .req_size_value(req_size_value),
      .rsp_strobe(rsp_strobe), .rsp_granted(rsp_granted),
      .rsp_chosen_index(rsp_chosen_index), .rsp_wastage(rsp_wastage),
      .rsp_total_wastage(rsp_total_wastage)
   );

   bfpa_grant_monitor #(.NUM_PARTITIONS(NUM_PARTITIONS)) grant_mon (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_block_index(req_block_index), .req_size_value(req_size_value),
      .rsp_strobe(rsp_strobe), .rsp_granted(rsp_granted),
      .rsp_chosen_index(rsp_chosen_index), .rsp_wastage(rsp_wastage),
      .rsp_total_wastage(rsp_total_wastage),
      .outstanding(outstanding), .mismatches(mismatches), .grant_count(grant_count),
      .miss_count(miss_count), .load_count(load_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("best_fit_partition_allocator regression: fail");
            $finish;
         end
      end
   end

   // sizes: extremes, a small pool for ties and exact fits, or anything
   function automatic logic [SIZE_W-1:0] draw_size();
      logic [SIZE_W-1:0] v;
      case ($urandom_range(0, 9))
         0:          v = '0;
         1:          v = '1;
         2, 3, 4, 5: v = size_pool[$urandom_range(0, 5)];
         6:          v = size_pool[$urandom_range(0, 5)] + 1'b1;
         default:    v = SIZE_W'($urandom);
      endcase
      return v;
   endfunction

   // present one request transaction and hold it until it is taken
   task automatic issue_request(logic op, logic [IDX_W-1:0] idx, logic [SIZE_W-1:0] size);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_block_index <= idx;
      req_size_value <= size;
      if (op == OP_ALLOC) alloc_count++;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // stop sending and wait for every expected result
   task automatic drain_outstanding();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int load_pct;
      logic op;
      reset = 1'b1;
      start = 1'b0;
      req_op = OP_LOAD;
      req_block_index = '0;
      req_size_value = '0;
      alloc_count = 0;
      no_gaps = 1'b0;
      load_pct = 50;
      for (int i = 0; i < 6; i++)
         size_pool[i] = (i < 3) ? SIZE_W'($urandom_range(0, 255)) : SIZE_W'($urandom);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // fill every partition once so no scan touches an unwritten size
      for (int i = 0; i < NUM_PARTITIONS; i++)
         issue_request(OP_LOAD, IDX_W'(i), SIZE_W'($urandom_range(1, 59999)));

      // largest size, exact fit, then nothing fits
      issue_request(OP_LOAD, 6'd63, 16'hFFFF);
      issue_request(OP_ALLOC, 6'h00, 16'hFFFF);
      issue_request(OP_ALLOC, 6'h3F, 16'hFFFF);
      issue_request(OP_ALLOC, 6'h15, 16'd60000);
      // reload of a taken partition, zero-size request
      issue_request(OP_LOAD, 6'd63, 16'hFFFF);
      issue_request(OP_ALLOC, 6'h2A, 16'd0);
      // equal sizes: lowest index first
      issue_request(OP_LOAD, 6'd10, 16'd7);
      issue_request(OP_LOAD, 6'd20, 16'd7);
      issue_request(OP_ALLOC, 6'h3F, 16'd7);
      issue_request(OP_ALLOC, 6'h00, 16'd7);
      // zero-size partition
      issue_request(OP_LOAD, 6'd0, 16'd0);
      issue_request(OP_ALLOC, 6'h3F, 16'd0);
      // three-way tie at the top size
      issue_request(OP_LOAD, 6'd1, 16'hFFFF);
      issue_request(OP_LOAD, 6'd2, 16'hFFFF);
      issue_request(OP_ALLOC, 6'h00, 16'hFFFF);
      issue_request(OP_ALLOC, 6'h00, 16'hFFFF);
      issue_request(OP_ALLOC, 6'h00, 16'hFFFF);
      issue_request(OP_ALLOC, 6'h00, 16'hFFFF);
      drain_outstanding();

      // random part: load-heavy and allocate-heavy phases, bursts without gaps
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) no_gaps = ($urandom_range(0, 2) == 0);
         if (n % 150 == 0) load_pct = ((n / 150) % 2 == 0) ? 65 : 35;
         if (n == RANDOM_ITEMS / 2) drain_outstanding();
         op = ($urandom_range(0, 99) < load_pct) ? OP_LOAD : OP_ALLOC;
         issue_request(op, IDX_W'($urandom_range(0, IDX_DEPTH - 1)), draw_size());
      end

      drain_outstanding();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d loads and %0d allocates: %0d granted, %0d with no fit",
               load_count, alloc_count, grant_count, miss_count);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0) begin
         $display("best_fit_partition_allocator regression: pass");
      end else begin
         $display("best_fit_partition_allocator regression: fail");
      end
      $finish;
   end

endmodule
